/* design/elld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elld_pkg: shared types and constants of the event log line decoder
// Command format between front and back, byte codes and register indexes.
// ----------------------------------------------------------------------------
package elld_pkg;

    localparam int SEC_W   = 29;
    localparam int FRAC_W  = 20;
    localparam int TIME_W  = 48;
    localparam int PROD_W  = SEC_W + FRAC_W;
    localparam int CFG_W   = 48;
    localparam int REG_INDEX_W = 1;

    localparam logic [SEC_W-1:0]  SEC_MAX        = '1;
    localparam logic [TIME_W-1:0] TIME_MAX       = '1;
    localparam logic [FRAC_W-1:0] MICROS_PER_SEC = 20'd1000000;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_WINDOW_START = 1'b0,
        REG_WINDOW_END   = 1'b1
    } reg_index_t;

    typedef enum logic {
        CMD_OPEN = 1'b0,   // payload opens: time of the line in sec and padded fraction
        CMD_BYTE = 1'b1    // one unescaped payload byte
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [SEC_W-1:0]  sec;
        logic [FRAC_W-1:0] frac;
    } cmd_t;

endpackage

/* design/elld_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elld_front: line parser
// Walks each log byte through the line state machine, accumulates the
// timestamp token and issues payload commands to the queue.
// ----------------------------------------------------------------------------
module elld_front
    import elld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       restart,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        M_LINE_START = 3'd0,
        M_GAP        = 3'd1,
        M_TOKEN      = 3'd2,
        M_SKIP       = 3'd3,
        M_PAYLOAD    = 3'd4,
        M_AFTER      = 3'd5
    } mode_t;

    typedef struct packed {
        logic              dot;
        logic [2:0]        digits;
        logic [SEC_W-1:0]  sec;
        logic [FRAC_W-1:0] frac;   // already scaled to microseconds
    } time_state_t;

    typedef struct packed {
        logic        ok;
        time_state_t acc;
    } time_step_t;

    // weight of the next fraction digit, indexed by digits already taken
    localparam logic [16:0] POW10 [6] = '{17'd100000, 17'd10000, 17'd1000,
                                          17'd100, 17'd10, 17'd1};

    mode_t       mode_reg, mode_next;
    logic        esc_reg, esc_next;
    logic [1:0]  tc_reg, tc_next;
    time_state_t time_reg, time_next;

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF;
    endfunction

    function automatic time_step_t time_step(input logic [7:0] b, input time_state_t cur);
        time_step_t       r;
        logic [3:0]       d;
        logic [SEC_W+3:0] s;
        logic [20:0]      w;
        r.ok  = 1'b0;
        r.acc = cur;
        d     = b[3:0];
        s     = (SEC_W+4)'({cur.sec, 3'b000}) + (SEC_W+4)'({cur.sec, 1'b0})
              + (SEC_W+4)'(d);
        w     = 21'(d) * 21'(POW10[cur.digits]);
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            r.ok = 1'b1;
            if (!cur.dot)
            begin
                r.acc.sec = (s > (SEC_W+4)'(SEC_MAX)) ? SEC_MAX : s[SEC_W-1:0];
            end
            else if (cur.digits < 3'd6)
            begin
                r.acc.frac   = cur.frac + w[FRAC_W-1:0];
                r.acc.digits = cur.digits + 3'd1;
            end
        end
        else if (b == CH_DOT && !cur.dot)
        begin
            r.ok      = 1'b1;
            r.acc.dot = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        logic       in_token;
        time_step_t ts;
        mode_next = mode_reg;
        esc_next  = esc_reg;
        tc_next   = tc_reg;
        time_next = time_reg;
        cmd_valid = 1'b0;
        cmd.kind  = CMD_BYTE;
        cmd.data  = in_byte;
        cmd.sec   = time_reg.sec;
        cmd.frac  = time_reg.frac;
        in_token  = 1'b0;
        ts        = '0;

        if (accept)
        begin
            if (restart)
            begin
                mode_next = M_LINE_START;
                esc_next  = 1'b0;
                tc_next   = 2'd0;
                time_next = '0;
            end
            cmd.sec  = time_next.sec;
            cmd.frac = time_next.frac;

            case (mode_next)
                M_PAYLOAD:
                begin
                    if (esc_next)
                    begin
                        esc_next  = 1'b0;
                        cmd_valid = 1'b1;
                        case (in_byte)
                            CH_BSLASH: cmd.data = CH_BSLASH;
                            CH_LOW_N:  cmd.data = CH_LF;
                            CH_LOW_R:  cmd.data = CH_CR;
                            CH_ZERO:   cmd.data = CH_NUL;
                            default:   cmd.data = in_byte;
                        endcase
                    end
                    else if (in_byte == CH_QUOTE)
                        mode_next = M_AFTER;
                    else if (in_byte == CH_BSLASH)
                        esc_next = 1'b1;
                    else
                        cmd_valid = 1'b1;
                end
                M_SKIP, M_AFTER:
                begin
                    if (in_byte == CH_LF)
                    begin
                        mode_next = M_LINE_START;
                        esc_next  = 1'b0;
                        tc_next   = 2'd0;
                        time_next = '0;
                    end
                end
                M_LINE_START:
                begin
                    if (in_byte == CH_HASH)
                        mode_next = M_SKIP;
                    else if (in_byte != CH_LF)
                    begin
                        mode_next = M_GAP;
                        in_token  = 1'b1;
                    end
                end
                M_GAP, M_TOKEN:
                    in_token = 1'b1;
                default:
                    mode_next = M_SKIP;
            endcase

            if (in_token)
            begin
                ts = time_step(in_byte, time_next);
                if (in_byte == CH_LF)
                begin
                    mode_next = M_LINE_START;
                    esc_next  = 1'b0;
                    tc_next   = 2'd0;
                    time_next = '0;
                end
                else if (mode_next == M_TOKEN && tc_next == 2'd2)
                begin
                    // inside the timestamp token
                    if (is_space(in_byte))
                    begin
                        tc_next   = 2'd3;
                        mode_next = M_GAP;
                    end
                    else if (in_byte == CH_QUOTE)
                    begin
                        tc_next   = 2'd3;
                        mode_next = M_PAYLOAD;
                        esc_next  = 1'b0;
                        cmd_valid = 1'b1;
                        cmd.kind  = CMD_OPEN;
                    end
                    else if (ts.ok)
                        time_next = ts.acc;
                    else
                        mode_next = M_SKIP;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    if (tc_next == 2'd3)
                    begin
                        mode_next = M_PAYLOAD;
                        esc_next  = 1'b0;
                        cmd_valid = 1'b1;
                        cmd.kind  = CMD_OPEN;
                    end
                    else
                        mode_next = M_SKIP;
                end
                else if (is_space(in_byte))
                    mode_next = M_GAP;
                else if (mode_next == M_GAP)
                begin
                    mode_next = M_TOKEN;
                    if (tc_next != 2'd3)
                    begin
                        tc_next = tc_next + 2'd1;
                        if (tc_next == 2'd2)
                        begin
                            // a dot may not open the timestamp
                            if (in_byte == CH_DOT || !ts.ok)
                                mode_next = M_SKIP;
                            else
                                time_next = ts.acc;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_LINE_START;
            esc_reg  <= 1'b0;
            tc_reg   <= 2'd0;
            time_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            tc_reg   <= tc_next;
            time_reg <= time_next;
        end
    end

endmodule

/* design/elld_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elld_queue: command queue
// Short register queue that lets the parser and the word packer stall apart.
// ----------------------------------------------------------------------------
module elld_queue
    import elld_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic out_valid,
    input  logic pop,
    output cmd_t out_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        logic do_push;
        logic do_pop;
        do_push     = push && !full;
        do_pop      = pop && out_valid;
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/elld_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elld_back: time and word packer
// Scales the line time, checks the window and packs payload bytes into
// events held in the output register.
// ----------------------------------------------------------------------------
module elld_back
    import elld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    input  cmd_t                   in_cmd,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [10:0]            out_x,
    output logic [9:0]             out_y,
    output logic                   out_polarity,
    output logic [TIME_W-1:0]      out_time
);

    logic [TIME_W-1:0] start_reg, end_reg;

    // stage 1: command with the seconds already scaled
    logic              s1_valid_reg;
    cmd_kind_t         s1_kind_reg;
    logic [7:0]        s1_data_reg;
    logic [FRAC_W-1:0] s1_frac_reg;
    logic [PROD_W-1:0] s1_prod_reg;

    // stage 2: line state and output register
    logic [TIME_W-1:0] line_time_reg;
    logic              in_win_reg;
    logic [1:0]        pos_reg;
    logic [23:0]       partial_reg, partial_next;
    logic              out_valid_reg;
    logic [10:0]       out_x_reg;
    logic [9:0]        out_y_reg;
    logic              out_pol_reg;
    logic [TIME_W-1:0] out_time_reg;

    logic              advance;
    logic [PROD_W:0]   t_sum;
    logic [TIME_W-1:0] t_sat;
    logic [31:0]       word;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign t_sum = {1'b0, s1_prod_reg} + (PROD_W+1)'(s1_frac_reg);
    assign t_sat = (t_sum > (PROD_W+1)'(TIME_MAX)) ? TIME_MAX : t_sum[TIME_W-1:0];
    assign word  = {s1_data_reg, partial_reg};

    always_comb
    begin
        partial_next = partial_reg;
        partial_next[pos_reg*8 +: 8] = s1_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= TIME_MAX;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_WINDOW_START: start_reg <= cfg_data;
                REG_WINDOW_END:   end_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_kind_reg  <= CMD_BYTE;
            s1_data_reg  <= '0;
            s1_frac_reg  <= '0;
            s1_prod_reg  <= '0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            s1_kind_reg  <= in_cmd.kind;
            s1_data_reg  <= in_cmd.data;
            s1_frac_reg  <= in_cmd.frac;
            s1_prod_reg  <= PROD_W'(in_cmd.sec) * PROD_W'(MICROS_PER_SEC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_time_reg <= '0;
            in_win_reg    <= 1'b0;
            pos_reg       <= 2'd0;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_pol_reg   <= 1'b0;
            out_time_reg  <= '0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                case (s1_kind_reg)
                    CMD_OPEN:
                    begin
                        line_time_reg <= t_sat;
                        in_win_reg    <= (t_sat >= start_reg) && (t_sat < end_reg);
                        pos_reg       <= 2'd0;
                        partial_reg   <= '0;
                    end
                    CMD_BYTE:
                    begin
                        if (in_win_reg)
                        begin
                            if (pos_reg != 2'd3)
                            begin
                                partial_reg <= partial_next;
                                pos_reg     <= pos_reg + 2'd1;
                            end
                            else
                            begin
                                partial_reg   <= '0;
                                pos_reg       <= 2'd0;
                                out_valid_reg <= 1'b1;
                                out_x_reg     <= word[11:1];
                                out_y_reg     <= word[21:12];
                                out_pol_reg   <= word[0];
                                out_time_reg  <= line_time_reg;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_polarity = out_pol_reg;
    assign out_time     = out_time_reg;

endmodule

/* design/event_log_line_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_log_line_decoder: text event log to event stream
// Parses log lines byte by byte and emits one event per 4 payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one log byte per request in tdata; tuser set on a byte
//   returns the parser to the start of a new file before that byte is taken.
//   m_axis carries one event per request: x, y, polarity and the saturated
//   line time in microseconds. Only lines whose time lies inside
//   [window_start_us, window_end_us) give events; both bounds are written
//   through the cfg port (index 0 start, index 1 end) while the block idles.
// Throughput: one byte per cycle while the command queue has room. The
//   parser settles each byte in its cycle; the 29 x 20 bit seconds scaling
//   sits in its own stage. An event is valid on m_axis after the byte that
//   completes its word has passed queue write, scaling stage and output register.
// Reset: parser back to line start, queue empty, no event pending, window
//   open over the whole 48-bit range.
// Stall: the output register holds an event until taken; bytes keep flowing
//   into the command queue until it fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module event_log_line_decoder
    import elld_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    // byte input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    input  logic                   s_axis_tuser,   // [0] restart
    // event output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [71:0]            m_axis_tdata    // [10:0] event_x, [20:11] event_y,
                                                   // [21] event_polarity,
                                                   // [69:22] event_time_us, [71:70] zero
);

    logic              accept;
    logic              cmd_valid;
    cmd_t              cmd;
    logic              q_full;
    logic              q_valid;
    cmd_t              q_cmd;
    logic              back_ready;
    logic [10:0]       event_x;
    logic [9:0]        event_y;
    logic              event_polarity;
    logic [TIME_W-1:0] event_time_us;

    // take a byte whenever the queue has a free slot
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    elld_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_axis_tdata),
        .restart   (s_axis_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    elld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_cmd  (cmd),
        .full      (q_full),
        .out_valid (q_valid),
        .pop       (back_ready),
        .out_cmd   (q_cmd)
    );

    elld_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (q_valid),
        .in_cmd       (q_cmd),
        .in_ready     (back_ready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_x        (event_x),
        .out_y        (event_y),
        .out_polarity (event_polarity),
        .out_time     (event_time_us)
    );

    // pack the event, x in the lowest bits
    assign m_axis_tdata = {2'b00, event_time_us, event_polarity, event_y, event_x};

endmodule

/* design/elld_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elld_checker: port checks of the event log line decoder
// Watches the top-level ports; bound to every instance of the decoder.
// ----------------------------------------------------------------------------
module elld_checker
    import elld_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_we,
    input logic [REG_INDEX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]       cfg_data,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [71:0]            m_axis_tdata
);

    logic [TIME_W-1:0] start_reg, end_reg;

    // track the window as written on the port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= TIME_MAX;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_WINDOW_START: start_reg <= cfg_data;
                REG_WINDOW_END:   end_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // every event carries a time inside the window
    a_time_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[69:22] >= start_reg &&
                           m_axis_tdata[69:22] < end_reg))
        else $error("event time outside the window");

    // queue fills only on byte requests, so ready cannot drop without one
    a_ready_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && !s_axis_tvalid) |=> s_axis_tready)
        else $error("s_axis_tready dropped with no byte taken");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:70] == 2'b00)
        else $error("tdata pad bits set");

    // a stalled event holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled event changed");

endmodule

bind event_log_line_decoder elld_checker u_elld_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the event log line decoder
// Feeds text log lines byte by byte (directed lines, then random well-formed
// lines mixed with malformed ones) under several time windows, predicts every
// event and compares each event taken from the output stream field by field.
// ----------------------------------------------------------------------------
module testbench;

    import elld_pkg::*;

    // Give a settled block this many cycles before a register write or the end.
    localparam int SETTLE_CYCLES  = 24;
    // End the run when no request moves on either side for this long.
    localparam int WATCHDOG_LIMIT = 3000;
    // Length of the long output stall that backs the block up.
    localparam int HOLD_CYCLES    = 300;

    typedef enum logic [2:0] {
        PM_LINE_START,
        PM_GAP,
        PM_TOKEN,
        PM_SKIP,
        PM_PAYLOAD,
        PM_AFTER
    } parse_mode_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_us;
        logic              pol;
        logic [9:0]        y;
        logic [10:0]       x;
    } event_t;

    // One byte request: the byte and the restart flag that travels with it.
    typedef struct packed {
        logic       rs;
        logic [7:0] b;
    } log_req_t;

    // ------------------------------------------------------------------------
    // Line parser model and store of events still due from the block
    // ------------------------------------------------------------------------
    class log_event_checker;
        logic [TIME_W-1:0] win_start;
        logic [TIME_W-1:0] win_end;

        parse_mode_t       mode;
        bit                esc_pending;
        logic [1:0]        tok_count;
        logic [SEC_W-1:0]  sec_acc;
        logic [FRAC_W-1:0] frac_acc;
        logic [2:0]        frac_digits;
        bit                dot_seen;
        logic [TIME_W-1:0] line_time;
        bit                in_window;
        logic [1:0]        byte_pos;
        logic [23:0]       word_lo;

        event_t            events_due[$];
        int unsigned       fault_count;

        function new();
            win_start    = '0;
            win_end      = TIME_MAX;
            mode         = PM_LINE_START;
            fault_count  = 0;
            clear_line();
        endfunction

        function void set_window(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
            win_start = lo;
            win_end   = hi;
        endfunction

        function void clear_line();
            esc_pending = 1'b0;
            tok_count   = '0;
            sec_acc     = '0;
            frac_acc    = '0;
            frac_digits = '0;
            dot_seen    = 1'b0;
            line_time   = '0;
            in_window   = 1'b0;
            byte_pos    = '0;
            word_lo     = '0;
        endfunction

        function bit is_ws(input logic [7:0] b);
            return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF;
        endfunction

        // Scale the timestamp to microseconds, padding the fraction to 6 digits.
        function void close_time();
            logic [63:0] frac;
            logic [63:0] secs;
            logic [63:0] t;
            frac = 64'(frac_acc);
            secs = 64'(sec_acc);
            for (int d = int'(frac_digits); d < 6; d++)
                frac = frac * 64'd10;
            t = secs * 64'd1000000 + frac;
            if (t > 64'(TIME_MAX))
                t = 64'(TIME_MAX);
            line_time = t[TIME_W-1:0];
            tok_count = 2'd3;
        endfunction

        function void open_payload();
            if (tok_count == 2'd3)
            begin
                in_window   = line_time >= win_start && line_time < win_end;
                byte_pos    = '0;
                word_lo     = '0;
                esc_pending = 1'b0;
                mode        = PM_PAYLOAD;
            end
            else
                mode = PM_SKIP;
        endfunction

        // One timestamp character; 0 means the token is malformed.
        function bit time_char(input logic [7:0] b);
            logic [63:0] s;
            if (b >= CH_ZERO && b <= CH_NINE)
            begin
                if (!dot_seen)
                begin
                    s = 64'(sec_acc);
                    s = s * 64'd10 + 64'(b - CH_ZERO);
                    sec_acc = (s > 64'(SEC_MAX)) ? SEC_MAX : s[SEC_W-1:0];
                end
                else if (frac_digits < 3'd6)
                begin
                    frac_acc = frac_acc * FRAC_W'(10) + FRAC_W'(b - CH_ZERO);
                    frac_digits++;
                end
                return 1'b1;
            end
            if (b == CH_DOT && !dot_seen)
            begin
                dot_seen = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Collect unescaped payload bytes into a little-endian word.
        function void take_payload(input logic [7:0] v);
            logic [31:0] w;
            event_t      e;
            if (!in_window)
                return;
            if (byte_pos < 2'd3)
            begin
                word_lo[8*byte_pos +: 8] = v;
                byte_pos++;
                return;
            end
            w         = {v, word_lo};
            e.x       = w[11:1];
            e.y       = w[21:12];
            e.pol     = w[0];
            e.time_us = line_time;
            events_due.insert(events_due.size(), e);
            byte_pos = '0;
            word_lo  = '0;
        endfunction

        // Advance the parser by one accepted byte request.
        function void take_log_byte(input logic [7:0] b, input logic rs);
            logic [7:0] v;
            if (rs)
            begin
                mode = PM_LINE_START;
                clear_line();
            end

            case (mode)
                PM_PAYLOAD:
                begin
                    if (esc_pending)
                    begin
                        esc_pending = 1'b0;
                        case (b)
                            CH_BSLASH: v = CH_BSLASH;
                            CH_LOW_N:  v = CH_LF;
                            CH_LOW_R:  v = CH_CR;
                            CH_ZERO:   v = CH_NUL;
                            default:   v = b;
                        endcase
                        take_payload(v);
                        return;
                    end
                    if (b == CH_QUOTE)
                    begin
                        byte_pos = '0;
                        word_lo  = '0;
                        mode     = PM_AFTER;
                    end
                    else if (b == CH_BSLASH)
                        esc_pending = 1'b1;
                    else
                        take_payload(b);
                    return;
                end
                PM_SKIP, PM_AFTER:
                begin
                    if (b == CH_LF)
                    begin
                        mode = PM_LINE_START;
                        clear_line();
                    end
                    return;
                end
                PM_LINE_START:
                begin
                    if (b == CH_LF)
                        return;
                    if (b == CH_HASH)
                    begin
                        mode = PM_SKIP;
                        return;
                    end
                    mode = PM_GAP;
                end
                PM_GAP, PM_TOKEN: ;
                default:
                begin
                    mode = PM_SKIP;
                    return;
                end
            endcase

            // token part of a line
            if (b == CH_LF)
            begin
                mode = PM_LINE_START;
                clear_line();
                return;
            end
            if (mode == PM_TOKEN && tok_count == 2'd2)
            begin
                if (is_ws(b))
                begin
                    close_time();
                    mode = PM_GAP;
                end
                else if (b == CH_QUOTE)
                begin
                    close_time();
                    open_payload();
                end
                else if (!time_char(b))
                    mode = PM_SKIP;
                return;
            end
            if (b == CH_QUOTE)
            begin
                open_payload();
                return;
            end
            if (is_ws(b))
            begin
                mode = PM_GAP;
                return;
            end
            if (mode == PM_GAP)
            begin
                mode = PM_TOKEN;
                if (tok_count < 2'd3)
                begin
                    tok_count++;
                    if (tok_count == 2'd2 && (b == CH_DOT || !time_char(b)))
                        mode = PM_SKIP;
                end
            end
        endfunction

        // Compare one event taken from the block with the oldest one due.
        function void check_event(input logic [71:0] d);
            event_t got;
            event_t want;
            got.x       = d[10:0];
            got.y       = d[20:11];
            got.pol     = d[21];
            got.time_us = d[69:22];
            if (events_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("event with none due: x=%0d y=%0d p=%0d t=%0d",
                             got.x, got.y, got.pol, got.time_us);
                return;
            end
            want = events_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.pol !== want.pol ||
                got.time_us !== want.time_us)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("event mismatch: expected x=%0d y=%0d p=%0d t=%0d, ",
                             want.x, want.y, want.pol, want.time_us,
                             "got x=%0d y=%0d p=%0d t=%0d",
                             got.x, got.y, got.pol, got.time_us);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [REG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;   // [7:0] in_byte
    logic                   s_axis_tuser  = 1'b0; // [0] restart
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [71:0]            m_axis_tdata;         // [10:0] x, [20:11] y, [21] polarity,
                                                  // [69:22] time_us, [71:70] zero

    log_event_checker chk = new();
    log_req_t         line_q[$];

    int unsigned src_idle_pct = 22;
    int unsigned snk_idle_pct = 51;
    bit          hold_start   = 1'b0;
    int unsigned quiet_cycles = 0;

    event_log_line_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: values read here are those before the edge, so the byte and
    // event requests seen are exactly the ones the block takes at this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            chk.take_log_byte(s_axis_tdata, s_axis_tuser);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            chk.check_event(m_axis_tdata);
    end

    // Watchdog: count cycles in which no request moves on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    // The hold-off is counted here so the sender runs on regardless and the
    // block has to fill its queue and drop s_axis_tready.
    initial
    begin : sink_ready
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_left  = HOLD_CYCLES;
                hold_start = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Line building
    // ------------------------------------------------------------------------
    function automatic void push_chr(input logic [7:0] c);
        log_req_t r;
        r.rs = 1'b0;
        r.b  = c;
        line_q.insert(line_q.size(), r);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_chr(s[i]);
    endfunction

    // Token separators other than LF.
    function automatic void push_ws(input int unsigned n);
        repeat (n)
        begin
            case ($urandom_range(0, 4))
                0:       push_chr(CH_TAB);
                1:       push_chr(CH_CR);
                2:       push_chr(CH_VT);
                3:       push_chr(CH_FF);
                default: push_chr(CH_SPACE);
            endcase
        end
    endfunction

    function automatic void push_word();
        repeat ($urandom_range(1, 3))
            push_chr(8'($urandom_range(8'h61, 8'h7A)));
    endfunction

    // Any bytes but LF, so the line does not end early.
    function automatic void push_junk(input int unsigned n);
        logic [7:0] c;
        repeat (n)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_LF)
                c = CH_SPACE;
            push_chr(c);
        end
    endfunction

    // Quoted payload of n bytes after unescaping.
    function automatic void push_payload(input int unsigned n);
        logic [7:0] c;
        push_chr(CH_QUOTE);
        repeat (n)
        begin
            c = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:
                begin
                    push_chr(CH_BSLASH);
                    case ($urandom_range(0, 3))
                        0:       push_chr(CH_BSLASH);
                        1:       push_chr(CH_LOW_N);
                        2:       push_chr(CH_LOW_R);
                        default: push_chr(CH_ZERO);
                    endcase
                end
                1:
                begin
                    // escaped plain byte, a quote among them
                    push_chr(CH_BSLASH);
                    push_chr(c);
                end
                default:
                begin
                    if (c == CH_QUOTE || c == CH_BSLASH)
                        push_chr(CH_BSLASH);
                    push_chr(c);
                end
            endcase
        end
        push_chr(CH_QUOTE);
    endfunction

    // Timestamp text: small times, the window edges, saturating times and
    // odd but legal spellings.
    function automatic string rand_timestamp();
        int unsigned    k;
        logic [63:0]    t;
        string          s;
        k = $urandom_range(0, 99);
        if (k < 55)
        begin
            s = $sformatf("%0d", $urandom_range(0, 9));
            if ($urandom_range(0, 3) != 0)
            begin
                s = {s, "."};
                repeat ($urandom_range(0, 8))
                    s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
        end
        else if (k < 85)
        begin
            case ($urandom_range(0, 3))
                0:       t = 64'(chk.win_start);
                1:       t = 64'(chk.win_end);
                2:       t = (chk.win_start != 0) ? 64'(chk.win_start) - 64'd1 : 64'd0;
                default: t = (chk.win_end != 0) ? 64'(chk.win_end) - 64'd1 : 64'd0;
            endcase
            s = $sformatf("%0d.%06d", t / 1000000, t % 1000000);
            if ($urandom_range(0, 1))
                s = {s, "0"};
        end
        else if (k < 93)
            s = ($urandom_range(0, 1)) ? "999999999999.5" : "281474977";
        else
            s = $sformatf("00%0d.%0d", $urandom_range(0, 9), $urandom_range(0, 999999999));
        return s;
    endfunction

    function automatic void build_good_line();
        push_word();
        push_ws($urandom_range(1, 2));
        push_text(rand_timestamp());
        case ($urandom_range(0, 3))
            0: ;   // quote right after the time ends the token
            1:
            begin
                push_ws(1);
                push_word();
                push_ws(1);
            end
            default: push_ws($urandom_range(1, 2));
        endcase
        if ($urandom_range(0, 3) == 0)
            push_payload($urandom_range(0, 13));
        else
            push_payload(4 * $urandom_range(1, 3));
        if ($urandom_range(0, 2) == 0)
            push_junk($urandom_range(1, 5));
        push_chr(CH_LF);
        if ($urandom_range(0, 19) == 0)
            line_q[0].rs = 1'b1;
    endfunction

    function automatic void build_noise_line();
        case ($urandom_range(0, 6))
            0: ;   // empty line
            1:
            begin
                push_chr(CH_HASH);
                push_junk($urandom_range(0, 12));
            end
            2:
            begin
                // malformed time: leading dot, second dot or a letter
                push_word();
                push_ws(1);
                case ($urandom_range(0, 2))
                    0:       push_text(".5");
                    1:       push_text("1.2.3");
                    default: push_text("12a4");
                endcase
                push_ws(1);
                push_payload(4);
            end
            3:
            begin
                // quote before the time token
                if ($urandom_range(0, 1))
                begin
                    push_word();
                    push_ws(1);
                end
                push_payload(4);
            end
            4:
            begin
                push_word();
                push_ws(1);
                push_text(rand_timestamp());
                push_ws(1);
                push_word();
            end
            5:
            begin
                repeat ($urandom_range(1, 20))
                    push_chr(8'($urandom_range(0, 255)));
            end
            default:
            begin
                // restart somewhere inside an otherwise good line
                build_good_line();
                line_q[$urandom_range(0, line_q.size() - 1)].rs = 1'b1;
            end
        endcase
        push_chr(CH_LF);
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic send_byte(input log_req_t r);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.b;
        s_axis_tuser  <= r.rs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_line();
        foreach (line_q[i])
            send_byte(line_q[i]);
        line_q.delete();
    endtask

    // Stop offering, wait for every due event, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (chk.events_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_START;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_WINDOW_END;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        chk.set_window(lo, hi);
    endtask

    task automatic random_lines(input int unsigned budget);
        int unsigned sent;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 70)
                build_good_line();
            else
                build_noise_line();
            sent += line_q.size();
            send_line();
        end
    endtask

    task automatic directed_lines();
        int unsigned mark;
        push_chr(CH_LF);                                   // empty line
        push_text("# note \"x\"");                         // comment holding a quote
        push_chr(CH_LF);
        // all-zero and all-one words at time zero
        push_text("a 0 \"");
        repeat (4) push_chr(8'h00);
        repeat (4) push_chr(8'hFF);
        push_text("\"");
        push_chr(CH_LF);
        // tab separator, quote ending the time, every escape, raw LF in the
        // payload, two leftover bytes, then ignored bytes after the payload
        push_text("a");
        push_chr(CH_TAB);
        push_text("1.5\"\\\\\\n\\r\\0\\q");
        push_chr(CH_LF);
        push_text("\"x");
        push_chr(CH_LF);
        push_text("a .5 \"ABCD\"");                        // time starts with a dot
        push_chr(CH_LF);
        push_text("a 1.2.3 \"ABCD\"");                     // second dot
        push_chr(CH_LF);
        push_text("\"ABCD\"");                             // quote too early
        push_chr(CH_LF);
        push_text("a 2");                                  // no quote at all
        push_chr(CH_CR);
        push_chr(CH_VT);
        push_chr(CH_FF);
        push_text("b");
        push_chr(CH_LF);
        push_text("a 999999999999.1234567 \"ABCD\"");      // saturating time
        push_chr(CH_LF);
        push_text("x 281474976.710654 \"WXYZ\"");          // largest time inside the window
        push_chr(CH_LF);
        push_text("a 3 \"AB");                             // cut short by a restart
        mark = line_q.size();
        push_text("b 4 \"CDEF\"");
        line_q[mark].rs = 1'b1;
        push_chr(CH_LF);
        send_line();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window, sender idles a little, receiver often
        src_idle_pct = 22;
        snk_idle_pct = 51;
        directed_lines();
        drain();

        // whole range written explicitly; start with a long output stall
        write_window('0, TIME_MAX);
        hold_start = 1'b1;
        random_lines(450);
        drain();

        // a few seconds wide, idling the other way round
        src_idle_pct = 51;
        snk_idle_pct = 22;
        write_window(48'd2000000, 48'd7000000);
        random_lines(400);
        drain();

        // from here on neither side idles
        src_idle_pct = 0;
        snk_idle_pct = 0;

        // only the largest unsaturated time fits
        write_window(TIME_MAX - 1, TIME_MAX);
        random_lines(200);
        drain();

        // empty window
        write_window('0, '0);
        random_lines(100);
        drain();

        // random window over the small times
        lo = TIME_W'($urandom_range(0, 6000000));
        hi = lo + TIME_W'($urandom_range(1000000, 6000000));
        write_window(lo, hi);
        random_lines(200);

        drain();
        if (chk.fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
design/elld_pkg.sv
design/elld_front.sv
design/elld_queue.sv
design/elld_back.sv
design/event_log_line_decoder.sv
design/elld_checker.sv
tb/sv/testbench.sv
